// ===== rtl/core/cca_pkg.sv =====
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types, widths and codes for the constraint color allocator.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int BODY_COUNT_DEF  = 1024;
    localparam int COLOR_COUNT_DEF = 32;
    localparam int BODY_IDX_W      = 10;
    localparam int COLOR_W         = 5;
    localparam int LIMIT_W         = 6;
    localparam int MODE_W          = 2;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [LIMIT_W-1:0] DYN_LIMIT_RESET  = 6'd24;
    localparam logic [LIMIT_W-1:0] STAT_LIMIT_RESET = 6'd8;

    localparam logic [MODE_W-1:0] MODE_JOINT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONTACT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;

    localparam logic CFG_DYN_LIMIT  = 1'b0;
    localparam logic CFG_STAT_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        OP_JOINT,
        OP_PAIR,
        OP_SINGLE,
        OP_REMOVE,
        OP_OVERFLOW,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [BODY_IDX_W-1:0] first_body;
        logic [BODY_IDX_W-1:0] second_body;
        logic                  first_dynamic;
        logic                  second_dynamic;
        logic [COLOR_W-1:0]    removed_color;
        logic                  removed_in_overflow;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] assigned_color;
        logic               overflowed;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic               first_dynamic;
        logic               second_dynamic;
        logic               same_body;
        logic [COLOR_W-1:0] color;
    } cmd_t;

endpackage

// ===== rtl/core/cca_front.sv =====
// ----------------------------------------------------------------------------
// cca_front
// Input side: maps body indices to slots and classifies each word into a
// command for the back end.
// ----------------------------------------------------------------------------
module cca_front
    import cca_pkg::*;
#(
    parameter int BODY_COUNT  = BODY_COUNT_DEF,
    parameter int COLOR_COUNT = COLOR_COUNT_DEF,
    localparam int ADDR_W     = $clog2(BODY_COUNT)
)
(
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    input  logic              queue_full,
    input  logic              clearing,
    output logic              push,
    output cmd_t              cmd,
    output logic [ADDR_W-1:0] slot1,
    output logic [ADDR_W-1:0] slot2
);

    localparam int REM_W = (ADDR_W > BODY_IDX_W) ? ADDR_W : BODY_IDX_W;

    // Reduce an index modulo BODY_COUNT by shifted compare and subtract.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [BODY_IDX_W-1:0] idx);
        logic [REM_W-1:0] rem;
        rem = REM_W'(idx);
        for (int k = BODY_IDX_W - 1; k >= 0; k--)
        begin
            if ((BODY_COUNT << k) < (1 << BODY_IDX_W))
            begin
                if (32'(rem) >= 32'(BODY_COUNT << k))
                begin
                    rem = rem - REM_W'(BODY_COUNT << k);
                end
            end
        end
        return ADDR_W'(rem);
    endfunction

    logic rm_valid;

    assign item_ready = !queue_full && !clearing;
    assign push       = item_valid && item_ready;
    assign slot1      = slot_of(item.first_body);
    assign slot2      = slot_of(item.second_body);

    assign rm_valid = !item.removed_in_overflow
                      && (LIMIT_W'(item.removed_color) < LIMIT_W'(COLOR_COUNT))
                      && (item.first_dynamic || item.second_dynamic);

    always_comb
    begin
        cmd.first_dynamic  = item.first_dynamic;
        cmd.second_dynamic = item.second_dynamic;
        cmd.same_body      = (slot1 == slot2);
        cmd.color          = item.removed_color;
        case (item.mode)
            MODE_JOINT:
            begin
                cmd.op = OP_JOINT;
            end
            MODE_CONTACT:
            begin
                if (item.first_dynamic && item.second_dynamic)
                begin
                    cmd.op = OP_PAIR;
                end
                else if (item.first_dynamic || item.second_dynamic)
                begin
                    cmd.op = OP_SINGLE;
                end
                else
                begin
                    cmd.op = OP_OVERFLOW;
                end
            end
            MODE_REMOVE:
            begin
                cmd.op = rm_valid ? OP_REMOVE : OP_NOP;
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/core/cca_queue.sv =====
// ----------------------------------------------------------------------------
// cca_queue
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cca_queue
    import cca_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head_data = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/cca_back.sv =====
// ----------------------------------------------------------------------------
// cca_back
// Execution side: owns the body mask memory, clears it after reset, reads
// both masks, picks a color, writes the masks back and holds the result.
// ----------------------------------------------------------------------------
module cca_back
    import cca_pkg::*;
#(
    parameter int BODY_COUNT  = BODY_COUNT_DEF,
    parameter int COLOR_COUNT = COLOR_COUNT_DEF,
    localparam int ADDR_W     = $clog2(BODY_COUNT)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LIMIT_W-1:0] dyn_limit,
    input  logic [LIMIT_W-1:0] stat_limit,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    input  logic [ADDR_W-1:0]  q_slot1,
    input  logic [ADDR_W-1:0]  q_slot2,
    output logic               q_pop,
    output logic               clearing,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result
);

    localparam logic [LIMIT_W-1:0] COLORS = LIMIT_W'(COLOR_COUNT);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_WRITE2
    } state_t;

    function automatic logic [LIMIT_W-1:0] lowest_free(input logic [COLOR_COUNT-1:0] used);
        logic [LIMIT_W-1:0] r;
        r = COLORS;
        for (int c = COLOR_COUNT - 1; c >= 0; c--)
        begin
            if (!used[c])
            begin
                r = LIMIT_W'(c);
            end
        end
        return r;
    endfunction

    function automatic logic [LIMIT_W-1:0] top_used_run(input logic [COLOR_COUNT-1:0] used);
        logic [LIMIT_W-1:0] r;
        r = COLORS;
        for (int k = COLOR_COUNT - 1; k >= 0; k--)
        begin
            if (!used[COLOR_COUNT-1-k])
            begin
                r = LIMIT_W'(k);
            end
        end
        return r;
    endfunction

    logic [COLOR_COUNT-1:0] mem [BODY_COUNT];
    logic [COLOR_COUNT-1:0] rd1_reg;
    logic [COLOR_COUNT-1:0] rd2_reg;

    state_t                 state_reg;
    state_t                 state_next;
    logic [ADDR_W-1:0]      clr_idx_reg;
    logic [ADDR_W-1:0]      clr_idx_next;
    cmd_t                   cur_reg;
    cmd_t                   cur_next;
    logic [ADDR_W-1:0]      slot1_reg;
    logic [ADDR_W-1:0]      slot1_next;
    logic [ADDR_W-1:0]      slot2_reg;
    logic [ADDR_W-1:0]      slot2_next;
    logic [COLOR_COUNT-1:0] wdata2_reg;
    logic [COLOR_COUNT-1:0] wdata2_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    result_t                result_reg;
    result_t                result_next;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COLOR_COUNT-1:0] mem_wdata;

    logic                   out_free;
    logic [LIMIT_W-1:0]     lf;
    logic [LIMIT_W-1:0]     run;
    logic [LIMIT_W-1:0]     pick;
    logic                   ok;
    logic                   is_add;
    logic                   is_ovf;
    logic                   wr_act;
    logic                   set_bit;
    logic                   do_w1;
    logic                   do_w2;
    logic [COLOR_W-1:0]     bit_idx;
    logic [COLOR_COUNT-1:0] bit_vec;
    logic [COLOR_COUNT-1:0] new1;
    logic [COLOR_COUNT-1:0] new2;

    assign out_free     = !result_valid_reg || result_ready;
    assign clearing     = (state_reg == ST_CLEAR);
    assign q_pop        = (state_reg == ST_IDLE) && q_valid;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign lf  = lowest_free(rd1_reg | rd2_reg);
    assign run = top_used_run(cur_reg.first_dynamic ? rd1_reg : rd2_reg);

    always_comb
    begin
        ok      = 1'b0;
        is_add  = 1'b0;
        is_ovf  = 1'b0;
        set_bit = 1'b1;
        pick    = lf;
        case (cur_reg.op)
            OP_JOINT:
            begin
                is_add = 1'b1;
                ok     = (lf < COLORS);
            end
            OP_PAIR:
            begin
                is_add = 1'b1;
                ok     = (lf < COLORS) && (lf < dyn_limit);
            end
            OP_SINGLE:
            begin
                is_add = 1'b1;
                ok     = (run < COLORS) && (run < stat_limit);
                pick   = COLORS - 1'b1 - run;
            end
            OP_REMOVE:
            begin
                set_bit = 1'b0;
            end
            OP_OVERFLOW:
            begin
                is_ovf = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        bit_idx = set_bit ? pick[COLOR_W-1:0] : cur_reg.color;
        bit_vec = {{(COLOR_COUNT-1){1'b0}}, 1'b1} << bit_idx;
        new1    = set_bit ? (rd1_reg | bit_vec) : (rd1_reg & ~bit_vec);
        new2    = set_bit ? (rd2_reg | bit_vec) : (rd2_reg & ~bit_vec);
        wr_act  = (is_add && ok) || (cur_reg.op == OP_REMOVE);
        do_w1   = wr_act && cur_reg.first_dynamic;
        do_w2   = wr_act && cur_reg.second_dynamic
                  && !(cur_reg.same_body && cur_reg.first_dynamic);
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        cur_next          = cur_reg;
        slot1_next        = slot1_reg;
        slot2_next        = slot2_reg;
        wdata2_next       = wdata2_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = slot1_reg;
        mem_wdata         = new1;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ADDR_W'(BODY_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next   = q_cmd;
                    slot1_next = q_slot1;
                    slot2_next = q_slot2;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    result_valid_next          = 1'b1;
                    result_next.assigned_color = (is_add && ok) ? pick[COLOR_W-1:0] : '0;
                    result_next.overflowed     = is_ovf || (is_add && !ok);
                    wdata2_next                = new2;
                    state_next                 = ST_IDLE;
                    if (do_w1)
                    begin
                        mem_we = 1'b1;
                        if (do_w2)
                        begin
                            state_next = ST_WRITE2;
                        end
                    end
                    else if (do_w2)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = slot2_reg;
                        mem_wdata = new2;
                    end
                end
            end
            ST_WRITE2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot2_reg;
                mem_wdata  = wdata2_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        slot1_reg  <= slot1_next;
        slot2_reg  <= slot2_next;
        wdata2_reg <= wdata2_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd1_reg <= mem[q_slot1];
            rd2_reg <= mem[q_slot2];
        end
    end

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("command taken during mask clear");

    a_eval_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && out_free) |=> result_valid_reg)
        else $error("evaluated command produced no result");

    a_write2_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE2) |=> (state_reg == ST_IDLE))
        else $error("second mask write did not return to idle");

    a_overflow_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.overflowed) |-> (result_reg.assigned_color == '0))
        else $error("overflow result carries a color");

endmodule

// ===== rtl/core/constraint_color_allocator_core.sv =====
// ----------------------------------------------------------------------------
// constraint_color_allocator_core
// Greedy constraint coloring over per-body color masks.
// ----------------------------------------------------------------------------
// Flow: an accepted word is queued, then the idle back end pops it and registers its
//   result from the evaluate state; a second write state follows when two distinct
//   dynamic bodies are written, as the mask memory has a single write port.
// Reset: limits return to 24 and 8; the mask memory is then cleared one entry per
//   cycle over all BODY_COUNT entries, with item_ready held low.
// ----------------------------------------------------------------------------
module constraint_color_allocator_core
    import cca_pkg::*;
#(
    parameter int BODY_COUNT  = BODY_COUNT_DEF,
    parameter int COLOR_COUNT = COLOR_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(BODY_COUNT);
    localparam int Q_W    = $bits(cmd_t) + 2 * ADDR_W;

    logic [LIMIT_W-1:0] dyn_limit_reg;
    logic [LIMIT_W-1:0] dyn_limit_next;
    logic [LIMIT_W-1:0] stat_limit_reg;
    logic [LIMIT_W-1:0] stat_limit_next;

    logic               push;
    cmd_t               f_cmd;
    logic [ADDR_W-1:0]  f_slot1;
    logic [ADDR_W-1:0]  f_slot2;
    logic [Q_W-1:0]     q_head;
    logic               q_valid;
    logic               q_full;
    logic               q_pop;
    logic               clearing;
    cmd_t               b_cmd;
    logic [ADDR_W-1:0]  b_slot1;
    logic [ADDR_W-1:0]  b_slot2;

    always_comb
    begin
        dyn_limit_next  = dyn_limit_reg;
        stat_limit_next = stat_limit_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_DYN_LIMIT:  dyn_limit_next  = cfg_data;
                CFG_STAT_LIMIT: stat_limit_next = cfg_data;
                default:        dyn_limit_next  = dyn_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dyn_limit_reg  <= DYN_LIMIT_RESET;
            stat_limit_reg <= STAT_LIMIT_RESET;
        end
        else
        begin
            dyn_limit_reg  <= dyn_limit_next;
            stat_limit_reg <= stat_limit_next;
        end
    end

    cca_front #(
        .BODY_COUNT  (BODY_COUNT),
        .COLOR_COUNT (COLOR_COUNT)
    ) u_front (
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .queue_full  (q_full),
        .clearing    (clearing),
        .push        (push),
        .cmd         (f_cmd),
        .slot1       (f_slot1),
        .slot2       (f_slot2)
    );

    cca_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_cmd, f_slot1, f_slot2}),
        .pop       (q_pop),
        .head_data (q_head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    assign {b_cmd, b_slot1, b_slot2} = q_head;

    cca_back #(
        .BODY_COUNT  (BODY_COUNT),
        .COLOR_COUNT (COLOR_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dyn_limit    (dyn_limit_reg),
        .stat_limit   (stat_limit_reg),
        .q_valid      (q_valid),
        .q_cmd        (b_cmd),
        .q_slot1      (b_slot1),
        .q_slot2      (b_slot2),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== tb/color_checker.sv =====
// ----------------------------------------------------------------------------
// color_checker
// Watches the word and result channels of the constraint color allocator,
// keeps its own copy of the per-body color masks and the two color limits,
// predicts the color or overflow of every accepted word and compares each
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module color_checker
    import cca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  item_t              item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  result_t            result,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 mismatches,
    output int                 pending,
    output int                 checked,
    output int                 overflows
);

    localparam int BODIES      = BODY_COUNT_DEF;
    localparam int COLORS      = COLOR_COUNT_DEF;
    localparam int SHOW_LIMIT  = 10;

    logic [COLORS-1:0]  body_masks [BODIES];
    logic [LIMIT_W-1:0] dyn_limit;
    logic [LIMIT_W-1:0] stat_limit;
    result_t            expected_colors [$];
    result_t            want;
    result_t            predicted;

    function automatic int lowest_free(logic [COLORS-1:0] used);
        for (int c = 0; c < COLORS; c++)
        begin
            if (!used[c])
                return c;
        end
        return COLORS;
    endfunction

    function automatic int top_busy_run(logic [COLORS-1:0] used);
        for (int k = 0; k < COLORS; k++)
        begin
            if (!used[COLORS-1-k])
                return k;
        end
        return COLORS;
    endfunction

    function automatic result_t color_word(item_t w);
        int                b1;
        int                b2;
        int                pick;
        int                run;
        int                rc;
        logic              ok;
        logic [COLORS-1:0] m1;
        logic [COLORS-1:0] m2;
        result_t           r;
        b1   = int'(w.first_body) % BODIES;
        b2   = int'(w.second_body) % BODIES;
        m1   = body_masks[b1];
        m2   = body_masks[b2];
        rc   = int'(w.removed_color);
        r    = '0;
        ok   = 1'b0;
        pick = 0;
        case (w.mode)
            MODE_JOINT:
            begin
                pick = lowest_free(m1 | m2);
                ok   = (pick < COLORS);
            end
            MODE_CONTACT:
            begin
                if (w.first_dynamic && w.second_dynamic)
                begin
                    pick = lowest_free(m1 | m2);
                    ok   = (pick < COLORS) && (pick < int'(dyn_limit));
                end
                else if (w.first_dynamic || w.second_dynamic)
                begin
                    run = top_busy_run(w.first_dynamic ? m1 : m2);
                    if (run < COLORS && run < int'(stat_limit))
                    begin
                        pick = COLORS - 1 - run;
                        ok   = 1'b1;
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (!w.removed_in_overflow && rc < COLORS)
                begin
                    if (w.second_dynamic)
                        body_masks[b2][rc] = 1'b0;
                    if (w.first_dynamic)
                        body_masks[b1][rc] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (w.mode == MODE_JOINT || w.mode == MODE_CONTACT)
        begin
            if (ok)
            begin
                if (w.first_dynamic)
                    body_masks[b1][pick] = 1'b1;
                if (w.second_dynamic)
                    body_masks[b2][pick] = 1'b1;
                r.assigned_color = COLOR_W'(pick);
            end
            else
            begin
                r.overflowed = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (body_masks[i])
                body_masks[i] = '0;
            dyn_limit  = DYN_LIMIT_RESET;
            stat_limit = STAT_LIMIT_RESET;
            expected_colors.delete();
            mismatches = 0;
            pending    = 0;
            checked    = 0;
            overflows  = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    flag_mismatch($sformatf("result color %0d overflow %0b with none expected",
                                            result.assigned_color, result.overflowed));
                end
                else
                begin
                    want = expected_colors.pop_front();
                    checked++;
                    if (result.assigned_color !== want.assigned_color ||
                        result.overflowed !== want.overflowed)
                    begin
                        flag_mismatch($sformatf(
                            "expected color %0d overflow %0b, got color %0d overflow %0b",
                            want.assigned_color, want.overflowed,
                            result.assigned_color, result.overflowed));
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DYN_LIMIT:  dyn_limit  = cfg_data;
                    CFG_STAT_LIMIT: stat_limit = cfg_data;
                    default:        dyn_limit  = dyn_limit;
                endcase
            end
            if (item_valid && item_ready)
            begin
                predicted = color_word(item);
                if (predicted.overflowed)
                    overflows++;
                expected_colors.push_back(predicted);
            end
            pending = expected_colors.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the constraint color allocator with a directed set of joints,
// contacts and removes, then with random phases over several color limit
// settings and idle patterns; removes mostly target constraints placed
// earlier so masks fill up and drain. A side checker predicts every result.
// ----------------------------------------------------------------------------
module tb
    import cca_pkg::*;
();

    localparam int                CLK_HALF      = 5;
    localparam int                RESET_CYCLES  = 12;
    localparam int                CYCLE_LIMIT   = 200000;
    localparam int                PHASE_WORDS   = 205;
    localparam int                HOLD_CYCLES   = 80;
    localparam int                DRAIN_CYCLES  = 10;
    localparam logic [MODE_W-1:0] MODE_IGNORED  = 2'd3;

    typedef struct packed {
        item_t   word;
        result_t outcome;
    } placed_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    item_t              item;
    logic               result_valid;
    logic               result_ready;
    result_t            result;
    logic               cfg_write;
    logic               cfg_index;
    logic [LIMIT_W-1:0] cfg_data;

    int                    mismatches;
    int                    pending;
    int                    checked;
    int                    overflows;
    int                    cycles;
    int                    words_sent;
    int                    settings_used;
    int                    tx_idle_pct;
    int                    rx_stall_pct;
    bit                    hold_req;
    bit                    hold_done;
    int                    pool_span;
    logic [BODY_IDX_W-1:0] pool_base;
    item_t                 in_flight [$];
    placed_t               placed [$];
    item_t                 done_word;

    constraint_color_allocator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    color_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .overflows    (overflows)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // pair each result with its word so later removes can target it
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready && in_flight.size() > 0)
        begin
            done_word = in_flight.pop_front();
            if (done_word.mode == MODE_JOINT || done_word.mode == MODE_CONTACT)
                placed.push_back(placed_t'{word: done_word, outcome: result});
        end
    end

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            result_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic item_t mk(logic [MODE_W-1:0] m, int b1, int b2, bit d1, bit d2,
                                 int rc = 0, bit ro = 1'b0);
        item_t w;
        w.mode                = m;
        w.first_body          = BODY_IDX_W'(b1);
        w.second_body         = BODY_IDX_W'(b2);
        w.first_dynamic       = d1;
        w.second_dynamic      = d2;
        w.removed_color       = COLOR_W'(rc);
        w.removed_in_overflow = ro;
        return w;
    endfunction

    function automatic logic [BODY_IDX_W-1:0] pick_body();
        logic [BODY_IDX_W-1:0] b;
        if ($urandom_range(19) == 0)
            b = BODY_IDX_W'($urandom_range(1023));
        else
            b = pool_base + BODY_IDX_W'($urandom_range(pool_span - 1));
        return b;
    endfunction

    function automatic item_t next_word();
        item_t   w;
        int      roll;
        int      pick;
        placed_t p;
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            w = mk(MODE_W'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023),
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   $urandom_range(31), 1'($urandom_range(1)));
        end
        else if (roll < 40 && placed.size() > 0)
        begin
            pick = $urandom_range(placed.size() - 1);
            p    = placed[pick];
            placed.delete(pick);
            w                     = p.word;
            w.mode                = MODE_REMOVE;
            w.removed_color       = p.outcome.assigned_color;
            w.removed_in_overflow = p.outcome.overflowed;
        end
        else
        begin
            w.mode                = $urandom_range(1) ? MODE_CONTACT : MODE_JOINT;
            w.first_body          = pick_body();
            w.second_body         = ($urandom_range(19) == 0) ? w.first_body : pick_body();
            w.first_dynamic       = ($urandom_range(99) < 85);
            w.second_dynamic      = ($urandom_range(99) < 85);
            w.removed_color       = COLOR_W'($urandom_range(31));
            w.removed_in_overflow = 1'($urandom_range(1));
        end
        return w;
    endfunction

    task automatic send_word(input item_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do @(posedge clk); while (!item_ready);
        in_flight.push_back(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] dyn, input logic [LIMIT_W-1:0] stat,
                             input int tx_pct, input int rx_pct, input bit hold);
        item_t w;
        int    n;
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= CFG_DYN_LIMIT;
        cfg_data  <= dyn;
        @(negedge clk);
        cfg_index <= CFG_STAT_LIMIT;
        cfg_data  <= stat;
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold)
            hold_req = 1'b1;
        case ($urandom_range(3))
            0:       pool_span = 3;
            1:       pool_span = 6;
            2:       pool_span = 12;
            default: pool_span = 32;
        endcase
        pool_base = BODY_IDX_W'($urandom_range(1023));
        n = 0;
        while (n < PHASE_WORDS)
        begin
            w = next_word();
            send_word(w);
            if (w.mode != MODE_IGNORED)
                n++;
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_DYN_LIMIT;
        cfg_data      = '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        settings_used = 1;
        pool_span     = 4;
        pool_base     = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        send_word(mk(MODE_JOINT,   0,    1,    1, 1));
        send_word(mk(MODE_JOINT,   0,    1,    1, 1));
        send_word(mk(MODE_CONTACT, 0,    1,    1, 1));
        send_word(mk(MODE_CONTACT, 0,    1023, 1, 0));
        send_word(mk(MODE_CONTACT, 5,    2,    0, 1));
        send_word(mk(MODE_CONTACT, 6,    7,    0, 0));
        send_word(mk(MODE_JOINT,   1023, 512,  0, 0));
        send_word(mk(MODE_JOINT,   3,    3,    1, 1));
        send_word(mk(MODE_CONTACT, 3,    3,    1, 1));
        send_word(mk(MODE_JOINT,   0,    4,    0, 1));
        send_word(mk(MODE_REMOVE,  0,    1,    1, 1, 1, 1'b0));
        send_word(mk(MODE_REMOVE,  0,    1,    1, 1, 0, 1'b1));
        send_word(mk(MODE_IGNORED, 1023, 1023, 1, 1, 31, 1'b1));
        send_word(mk(MODE_REMOVE,  0,    1,    0, 1, 2, 1'b0));
        send_word(mk(MODE_REMOVE,  0,    1023, 1, 0, 31, 1'b0));
        send_word(mk(MODE_JOINT,   1023, 1023, 1, 1));
        // fill the static-contact band of one body until it overflows
        repeat (9) send_word(mk(MODE_CONTACT, 8, 1000, 1, 0));

        run_phase(6'd0,  6'd0,  0,  0,  1'b1);
        run_phase(6'd32, 6'd32, 52, 0,  1'b0);
        run_phase(6'd63, 6'd63, 0,  52, 1'b0);
        run_phase(6'd1,  6'd31, 24, 24, 1'b0);
        run_phase(6'd24, 6'd8,  0,  0,  1'b0);
        run_phase(LIMIT_W'($urandom_range(63)), LIMIT_W'($urandom_range(63)), 52, 0, 1'b0);
        run_phase(6'd31, 6'd1,  0,  52, 1'b0);
        run_phase(LIMIT_W'($urandom_range(63)), LIMIT_W'($urandom_range(63)), 24, 24, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d words under %0d limit settings, joints, contacts and removes",
                 words_sent, settings_used);
        $display("checked %0d results, %0d of them overflows, %0d mismatches",
                 checked, overflows, mismatches);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== constraint_color_allocator_core.f =====
rtl/core/cca_pkg.sv
rtl/core/cca_front.sv
rtl/core/cca_queue.sv
rtl/core/cca_back.sv
rtl/core/constraint_color_allocator_core.sv
tb/color_checker.sv
tb/tb.sv
